### sv/l3d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l3d_pkg
// Shared constants and types for the diagonal 3D color look-up table.
// ----------------------------------------------------------------------------
package l3d_pkg;

    localparam int GRID_SIZE     = 32;
    localparam int FRACTION_BITS = 12;
    localparam int NUM_CH        = 3;

    localparam int PIX_W     = 8;
    localparam int VALUE_W   = 13;
    localparam int ADDR_W    = 15;
    localparam int CELL_STEP = 256 / GRID_SIZE;
    localparam int STEP_BITS = $clog2(CELL_STEP);
    localparam int IDX_BITS  = $clog2(GRID_SIZE);

    localparam int NUM_W   = VALUE_W + STEP_BITS + 2;
    localparam int OUT_W   = 8;
    localparam int SCALE_W = NUM_W - 1 + OUT_W;
    localparam int SHIFT   = STEP_BITS + FRACTION_BITS;
    localparam int Q_W     = SCALE_W - SHIFT;
    localparam int OUT_MAX = 255;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_WRITE = 1'b1
    } req_type_t;

    typedef logic [NUM_CH-1:0][VALUE_W-1:0] entry_t;

    typedef struct packed {
        logic                               is_write;
        logic [ADDR_W-1:0]                  addr_a;
        logic [ADDR_W-1:0]                  addr_b;
        logic [NUM_CH-1:0][STEP_BITS-1:0]   low;
        entry_t                             data;
    } item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } qstat_t;

endpackage
`default_nettype wire

### sv/l3d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l3d_front
// Classifies an incoming transaction as a table write or a pixel and forms
// the two table addresses and the interpolation fractions of a pixel.
// ----------------------------------------------------------------------------
module l3d_front (
    input  wire logic                           req_type,
    input  wire logic [l3d_pkg::PIX_W-1:0]      pix_red,
    input  wire logic [l3d_pkg::PIX_W-1:0]      pix_green,
    input  wire logic [l3d_pkg::PIX_W-1:0]      pix_blue,
    input  wire logic [l3d_pkg::ADDR_W-1:0]     entry_index,
    input  wire logic [l3d_pkg::VALUE_W-1:0]    entry_red,
    input  wire logic [l3d_pkg::VALUE_W-1:0]    entry_green,
    input  wire logic [l3d_pkg::VALUE_W-1:0]    entry_blue,
    output l3d_pkg::item_t                      item
);

    logic [l3d_pkg::NUM_CH-1:0][l3d_pkg::PIX_W-1:0]    pix;
    logic [l3d_pkg::NUM_CH-1:0][l3d_pkg::IDX_BITS-1:0] grid_idx;
    logic [l3d_pkg::NUM_CH-1:0][l3d_pkg::IDX_BITS-1:0] grid_idx_up;

    assign pix = {pix_blue, pix_green, pix_red};

    always_comb begin
        for (int c = 0; c < l3d_pkg::NUM_CH; c++) begin
            grid_idx[c] = pix[c][l3d_pkg::PIX_W-1:l3d_pkg::STEP_BITS];
            if (grid_idx[c] == l3d_pkg::IDX_BITS'(l3d_pkg::GRID_SIZE - 1)) begin
                grid_idx[c] = l3d_pkg::IDX_BITS'(l3d_pkg::GRID_SIZE - 2);
            end
            grid_idx_up[c] = grid_idx[c] + l3d_pkg::IDX_BITS'(1);
        end
    end

    always_comb begin
        item.is_write = (l3d_pkg::req_type_t'(req_type) == l3d_pkg::REQ_WRITE);
        item.addr_a   = item.is_write ? entry_index
                                      : {grid_idx[2], grid_idx[1], grid_idx[0]};
        item.addr_b   = {grid_idx_up[2], grid_idx_up[1], grid_idx_up[0]};
        for (int c = 0; c < l3d_pkg::NUM_CH; c++) begin
            item.low[c] = pix[c][l3d_pkg::STEP_BITS-1:0];
        end
        item.data = {entry_blue, entry_green, entry_red};
    end

endmodule
`default_nettype wire

### sv/l3d_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l3d_queue
// Two-entry queue between the classifying front and the table back end.
// ----------------------------------------------------------------------------
module l3d_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire l3d_pkg::item_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_pop,
    output l3d_pkg::item_t       out_item,
    output l3d_pkg::qstat_t      stat
);

    l3d_pkg::item_t                 slot_reg [l3d_pkg::QUEUE_DEPTH];
    logic                           wr_ptr_reg, wr_ptr_next;
    logic                           rd_ptr_reg, rd_ptr_next;
    logic [l3d_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           push;
    logic                           pop;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == l3d_pkg::QCNT_W'(l3d_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    assign in_ready  = !stat.full;
    assign out_valid = !stat.empty;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + l3d_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - l3d_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

### sv/l3d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l3d_back
// Holds the color table, performs writes and dual-address pixel reads, and
// runs the interpolation pipeline up to the result register.
// ----------------------------------------------------------------------------
module l3d_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    input  wire l3d_pkg::item_t                 q_item,
    output logic                                q_pop,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [l3d_pkg::OUT_W-1:0]           m_out_red,
    output logic [l3d_pkg::OUT_W-1:0]           m_out_green,
    output logic [l3d_pkg::OUT_W-1:0]           m_out_blue
);

    localparam int DEPTH = 1 << l3d_pkg::ADDR_W;

    l3d_pkg::entry_t                    color_table [DEPTH];
    l3d_pkg::entry_t                    rd_a_reg;
    l3d_pkg::entry_t                    rd_b_reg;
    logic [l3d_pkg::NUM_CH-1:0][l3d_pkg::STEP_BITS-1:0] low_reg;

    logic                               advance;
    logic                               p1_valid_reg, p1_valid_next;
    logic                               p2_valid_reg, p2_valid_next;
    logic                               m_valid_reg, m_valid_next;

    logic signed [l3d_pkg::NUM_W-1:0]   start_x [l3d_pkg::NUM_CH];
    logic signed [l3d_pkg::NUM_W-1:0]   diff    [l3d_pkg::NUM_CH];
    logic signed [l3d_pkg::NUM_W-1:0]   low_x   [l3d_pkg::NUM_CH];
    logic signed [2*l3d_pkg::NUM_W-1:0] prod    [l3d_pkg::NUM_CH];
    logic signed [l3d_pkg::NUM_W-1:0]   num_next [l3d_pkg::NUM_CH];
    logic signed [l3d_pkg::NUM_W-1:0]   num_reg  [l3d_pkg::NUM_CH];

    logic [l3d_pkg::SCALE_W-1:0]        scaled  [l3d_pkg::NUM_CH];
    logic [l3d_pkg::Q_W-1:0]            quot    [l3d_pkg::NUM_CH];
    logic [l3d_pkg::OUT_W-1:0]          chan_next [l3d_pkg::NUM_CH];
    logic [l3d_pkg::OUT_W-1:0]          chan_reg  [l3d_pkg::NUM_CH];

    assign advance = !m_valid_reg || m_ready;
    assign q_pop   = advance && q_valid;

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.is_write) begin
            color_table[q_item.addr_a] <= q_item.data;
        end
        if (q_pop) begin
            rd_a_reg <= color_table[q_item.addr_a];
            rd_b_reg <= color_table[q_item.addr_b];
            low_reg  <= q_item.low;
        end
    end

    always_comb begin
        for (int c = 0; c < l3d_pkg::NUM_CH; c++) begin
            start_x[c] = signed'(l3d_pkg::NUM_W'({rd_a_reg[c], {l3d_pkg::STEP_BITS{1'b0}}}));
            diff[c]    = signed'(l3d_pkg::NUM_W'(rd_b_reg[c]))
                       - signed'(l3d_pkg::NUM_W'(rd_a_reg[c]));
            low_x[c]   = signed'(l3d_pkg::NUM_W'(low_reg[c]));
            prod[c]    = low_x[c] * diff[c];
            num_next[c] = start_x[c] + signed'(prod[c][l3d_pkg::NUM_W-1:0]);
        end
    end

    always_comb begin
        for (int c = 0; c < l3d_pkg::NUM_CH; c++) begin
            scaled[c] = {num_reg[c][l3d_pkg::NUM_W-2:0], {l3d_pkg::OUT_W{1'b0}}}
                      - l3d_pkg::SCALE_W'(num_reg[c][l3d_pkg::NUM_W-2:0]);
            quot[c]   = scaled[c][l3d_pkg::SCALE_W-1:l3d_pkg::SHIFT];
            if (num_reg[c] <= 0) begin
                chan_next[c] = '0;
            end else if (quot[c] > l3d_pkg::Q_W'(l3d_pkg::OUT_MAX)) begin
                chan_next[c] = l3d_pkg::OUT_W'(l3d_pkg::OUT_MAX);
            end else begin
                chan_next[c] = quot[c][l3d_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int c = 0; c < l3d_pkg::NUM_CH; c++) begin
                num_reg[c]  <= num_next[c];
                chan_reg[c] <= chan_next[c];
            end
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        p2_valid_next = p2_valid_reg;
        m_valid_next  = m_valid_reg;
        if (advance) begin
            p1_valid_next = q_pop && !q_item.is_write;
            p2_valid_next = p1_valid_reg;
            m_valid_next  = p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = chan_reg[0];
    assign m_out_green = chan_reg[1];
    assign m_out_blue  = chan_reg[2];

endmodule
`default_nettype wire

### sv/lut3d_diagonal_color_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lut3d_diagonal_color_map
// Maps RGB pixels through a 32x32x32 color table with diagonal interpolation.
//
// The s_ channel carries both table writes and pixels, selected by
// s_req_type. A table write stores one entry and returns no result. A pixel
// returns one m_ transaction with the three mapped channels. All entries a
// pixel touches must be written before the pixel is sent.
// One transaction is accepted per cycle while s_ready is high. A pixel accepted
// into the queue is handed to the dual-port table read registers, then the
// blend is registered, then the scaled result, which appears on m_valid.
// When m_valid is high and m_ready is low the back end pipeline holds, and
// the two-entry queue keeps taking transactions until it fills, after which
// s_ready drops. Reset empties the queue and the pipeline; table contents
// stay undefined until written, and no clearing pass is performed.
// ----------------------------------------------------------------------------
module lut3d_diagonal_color_map (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_req_type,
    input  wire logic [l3d_pkg::PIX_W-1:0]      s_pix_red,
    input  wire logic [l3d_pkg::PIX_W-1:0]      s_pix_green,
    input  wire logic [l3d_pkg::PIX_W-1:0]      s_pix_blue,
    input  wire logic [l3d_pkg::ADDR_W-1:0]     s_entry_index,
    input  wire logic [l3d_pkg::VALUE_W-1:0]    s_entry_red,
    input  wire logic [l3d_pkg::VALUE_W-1:0]    s_entry_green,
    input  wire logic [l3d_pkg::VALUE_W-1:0]    s_entry_blue,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [l3d_pkg::OUT_W-1:0]           m_out_red,
    output logic [l3d_pkg::OUT_W-1:0]           m_out_green,
    output logic [l3d_pkg::OUT_W-1:0]           m_out_blue
);

    l3d_pkg::item_t   front_item;
    l3d_pkg::item_t   q_item;
    l3d_pkg::qstat_t  q_stat;
    logic             q_valid;
    logic             q_pop;

    l3d_front u_front (
        .req_type    (s_req_type),
        .pix_red     (s_pix_red),
        .pix_green   (s_pix_green),
        .pix_blue    (s_pix_blue),
        .entry_index (s_entry_index),
        .entry_red   (s_entry_red),
        .entry_green (s_entry_green),
        .entry_blue  (s_entry_blue),
        .item        (front_item)
    );

    l3d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item),
        .stat      (q_stat)
    );

    l3d_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= l3d_pkg::QCNT_W'(l3d_pkg::QUEUE_DEPTH))
        else $error("Queue holds more transactions than its depth.");

    a_drain_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_stat.empty && !m_valid) |-> q_pop)
        else $error("Back end idles while the queue holds a transaction.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && q_stat.empty))
        else $error("Pipeline not empty after reset.");

endmodule
`default_nettype wire
